@@ sv/kuf_pkg.sv @@
// shared widths and reset constants for the kruskal union-find edge filter
`default_nettype none

package kuf_pkg;

    // fixed field widths of the edge and result beats
    localparam int VCOUNT_W = 11;
    localparam int WEIGHT_W = 16;
    localparam int TOTAL_W  = 26;
    localparam int EDGES_W  = 10;

    // default forest depth and the cap that the counters are sized for
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int COUNT_CAP        = 1024;

    // generation tag kept beside every forest entry
    localparam int EPOCH_W = 6;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(1024);

endpackage

`default_nettype wire

@@ sv/kruskal_union_find_edge_filter_unit.sv @@
// kruskal edge filter: union-find forest in a synchronous ram with compression and union by size
//
//   channel  direction  handshake            payload
//   edge     in         i_valid / o_stall    i_vertex_a, i_vertex_b, i_weight, i_new_graph
//   result   out        o_valid / i_stall    o_edge_taken, o_total_weight, o_edges_taken,
//                                            o_tree_complete, o_bad_vertex
//   config   in         i_cfg_we             i_cfg_data (vertex count)
//
// one edge beat is worked at a time; after accept, each end vertex is found by walking its links
// to the root and then pointing every node on that path at the root (compression), the two roots
// are compared, and a merge hangs the smaller tree under the larger and stores the summed size;
// a bad edge or a complete tree skips the walks and the merge.
// after reset a clearing pass over the whole forest runs before the first edge is taken;
// a new graph bumps a generation tag, and every 64th new graph costs another such pass.
// a waiting result sits in the output registers, so the next edge is taken while it stalls.
`default_nettype none

module kruskal_union_find_edge_filter_unit #(
    parameter int MAX_VERTICES = kuf_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration
    input  wire logic                         i_cfg_we,
    input  wire logic [kuf_pkg::VCOUNT_W-1:0] i_cfg_data,
    // edge channel
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [kuf_pkg::VCOUNT_W-1:0] i_vertex_a,
    input  wire logic [kuf_pkg::VCOUNT_W-1:0] i_vertex_b,
    input  wire logic [kuf_pkg::WEIGHT_W-1:0] i_weight,
    input  wire logic                         i_new_graph,
    // result channel
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_edge_taken,
    output logic [kuf_pkg::TOTAL_W-1:0]       o_total_weight,
    output logic [kuf_pkg::EDGES_W-1:0]       o_edges_taken,
    output logic                              o_tree_complete,
    output logic                              o_bad_vertex
);

    localparam int VTX_W = $clog2(MAX_VERTICES + 1);
    localparam int LW    = VTX_W + 1;
    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CAP   = (MAX_VERTICES < kuf_pkg::COUNT_CAP) ? MAX_VERTICES
                                                                : kuf_pkg::COUNT_CAP;

    localparam logic [kuf_pkg::VCOUNT_W-1:0] CAP_V      = kuf_pkg::VCOUNT_W'(CAP);
    localparam logic [VTX_W-1:0]             VTX_MAX    = VTX_W'(MAX_VERTICES);
    localparam logic [AW-1:0]                SWEEP_LAST = AW'(MAX_VERTICES - 1);

    typedef logic [VTX_W-1:0]            t_vtx;
    typedef logic signed [LW-1:0]        t_link;
    typedef logic [kuf_pkg::EPOCH_W-1:0] t_epoch;

    typedef struct packed {
        t_epoch epoch;
        t_link  link;
    } t_word;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_CHECK,
        S_FIND,
        S_WALK,
        S_CMP,
        S_MERGE1,
        S_MERGE2,
        S_DONE
    } t_state;

    localparam t_link LINK_ONE_ROOT = {LW{1'b1}};

    // forest memory
    t_word mem_forest [MAX_VERTICES];

    t_word              r_rdata;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    t_word              w_wdata;
    logic [AW-1:0]      w_raddr;

    // control and working registers
    t_state                           r_state,     n_state;
    logic [kuf_pkg::VCOUNT_W-1:0]     r_vcount,    n_vcount;
    t_epoch                           r_epoch,     n_epoch;
    logic [AW-1:0]                    r_sweep,     n_sweep;
    logic                             r_pend,      n_pend;
    logic                             r_which,     n_which;
    logic [kuf_pkg::TOTAL_W-1:0]      r_total,     n_total;
    logic [kuf_pkg::EDGES_W-1:0]      r_edges,     n_edges;
    logic                             r_out_valid, n_out_valid;

    t_vtx                             r_a,         n_a;
    t_vtx                             r_b,         n_b;
    logic [kuf_pkg::WEIGHT_W-1:0]     r_weight,    n_weight;
    logic                             r_bad,       n_bad;
    logic [kuf_pkg::EDGES_W-1:0]      r_target,    n_target;
    t_vtx                             r_cur,       n_cur;
    t_vtx                             r_root,      n_root;
    t_vtx                             r_ra,        n_ra;
    t_vtx                             r_rb,        n_rb;
    t_link                            r_la,        n_la;
    t_link                            r_lb,        n_lb;
    logic                             r_taken,     n_taken;

    logic                             r_o_taken,    n_o_taken;
    logic [kuf_pkg::TOTAL_W-1:0]      r_o_total,    n_o_total;
    logic [kuf_pkg::EDGES_W-1:0]      r_o_edges,    n_o_edges;
    logic                             r_o_complete, n_o_complete;
    logic                             r_o_bad,      n_o_bad;

    // combinational helpers
    logic [kuf_pkg::VCOUNT_W-1:0]     w_n;
    logic                             w_in_bad;
    t_link                            w_link;
    t_vtx                             w_next;
    logic                             w_next_ok;
    t_vtx                             w_start;
    t_link                            w_la_fix;
    t_link                            w_lb_fix;
    t_link                            w_sum;
    logic [kuf_pkg::TOTAL_W:0]        w_total_sum;

    function automatic logic [AW-1:0] f_addr(input t_vtx v);
        f_addr = AW'(v - VTX_W'(1));
    endfunction

    function automatic t_link f_as_link(input t_vtx v);
        f_as_link = t_link'({1'b0, v});
    endfunction

    // effective vertex count and range check of the incoming edge
    always_comb begin
        if (r_vcount == '0) begin
            w_n = kuf_pkg::VCOUNT_W'(1);
        end else if (r_vcount > CAP_V) begin
            w_n = CAP_V;
        end else begin
            w_n = r_vcount;
        end
        w_in_bad = (i_vertex_a == '0) || (i_vertex_a > w_n) ||
                   (i_vertex_b == '0) || (i_vertex_b > w_n);
    end

    // entry of an older generation reads as a root of size one
    assign w_link    = (r_rdata.epoch == r_epoch) ? r_rdata.link : LINK_ONE_ROOT;
    assign w_next    = w_link[VTX_W-1:0];
    assign w_next_ok = !w_link[LW-1] && (w_next != '0) && (w_next <= VTX_MAX);
    assign w_start   = r_which ? r_b : r_a;

    assign w_la_fix    = r_la[LW-1] ? r_la : LINK_ONE_ROOT;
    assign w_lb_fix    = r_lb[LW-1] ? r_lb : LINK_ONE_ROOT;
    assign w_sum       = w_la_fix + w_lb_fix;
    assign w_total_sum = {1'b0, r_total} + (kuf_pkg::TOTAL_W + 1)'(r_weight);

    always_comb begin
        n_state      = r_state;
        n_vcount     = r_vcount;
        n_epoch      = r_epoch;
        n_sweep      = r_sweep;
        n_pend       = r_pend;
        n_which      = r_which;
        n_total      = r_total;
        n_edges      = r_edges;
        n_out_valid  = r_out_valid;
        n_a          = r_a;
        n_b          = r_b;
        n_weight     = r_weight;
        n_bad        = r_bad;
        n_target     = r_target;
        n_cur        = r_cur;
        n_root       = r_root;
        n_ra         = r_ra;
        n_rb         = r_rb;
        n_la         = r_la;
        n_lb         = r_lb;
        n_taken      = r_taken;
        n_o_taken    = r_o_taken;
        n_o_total    = r_o_total;
        n_o_edges    = r_o_edges;
        n_o_complete = r_o_complete;
        n_o_bad      = r_o_bad;

        w_we    = 1'b0;
        w_waddr = f_addr(r_cur);
        w_wdata = '{epoch: r_epoch, link: f_as_link(r_root)};
        w_raddr = f_addr(r_cur);

        if (i_cfg_we) begin
            n_vcount = i_cfg_data;
        end

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_SWEEP: begin
                w_we    = 1'b1;
                w_waddr = r_sweep;
                w_wdata = '{epoch: '0, link: LINK_ONE_ROOT};
                n_sweep = r_sweep + AW'(1);
                if (r_sweep == SWEEP_LAST) begin
                    n_sweep = '0;
                    n_pend  = 1'b0;
                    n_state = r_pend ? S_CHECK : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_a      = VTX_W'(i_vertex_a);
                    n_b      = VTX_W'(i_vertex_b);
                    n_weight = i_weight;
                    n_bad    = w_in_bad;
                    n_target = kuf_pkg::EDGES_W'(w_n - kuf_pkg::VCOUNT_W'(1));
                    n_taken  = 1'b0;
                    n_state  = S_CHECK;
                    if (i_new_graph) begin
                        n_total = '0;
                        n_edges = '0;
                        // generation tag wraps: old entries must be wiped first
                        if (r_epoch == '1) begin
                            n_epoch = '0;
                            n_pend  = 1'b1;
                            n_state = S_SWEEP;
                        end else begin
                            n_epoch = r_epoch + t_epoch'(1);
                        end
                    end
                end
            end
            S_CHECK: begin
                if (r_bad || (r_edges >= r_target)) begin
                    n_state = S_DONE;
                end else begin
                    n_cur   = r_a;
                    n_which = 1'b0;
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                w_raddr = f_addr(r_cur);
                n_state = S_WALK;
            end
            S_WALK: begin
                if (!w_link[LW-1] && w_next_ok) begin
                    n_cur   = w_next;
                    w_raddr = f_addr(w_next);
                end else begin
                    // r_cur is the root of this end
                    if (r_which) begin
                        n_rb = r_cur;
                        n_lb = w_link;
                    end else begin
                        n_ra = r_cur;
                        n_la = w_link;
                    end
                    n_root = r_cur;
                    if (w_start == r_cur) begin
                        if (r_which) begin
                            n_state = S_MERGE1;
                        end else begin
                            n_which = 1'b1;
                            n_cur   = r_b;
                            n_state = S_FIND;
                        end
                    end else begin
                        n_cur   = w_start;
                        w_raddr = f_addr(w_start);
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                // point this node at the root, then follow its old link
                w_we    = 1'b1;
                w_waddr = f_addr(r_cur);
                w_wdata = '{epoch: r_epoch, link: f_as_link(r_root)};
                if (!w_next_ok || (w_next == r_root)) begin
                    if (r_which) begin
                        n_state = S_MERGE1;
                    end else begin
                        n_which = 1'b1;
                        n_cur   = r_b;
                        n_state = S_FIND;
                    end
                end else begin
                    n_cur   = w_next;
                    w_raddr = f_addr(w_next);
                end
            end
            S_MERGE1: begin
                if (r_ra == r_rb) begin
                    n_state = S_DONE;
                end else begin
                    w_we = 1'b1;
                    if (w_la_fix > w_lb_fix) begin
                        w_waddr = f_addr(r_ra);
                        w_wdata = '{epoch: r_epoch, link: f_as_link(r_rb)};
                    end else begin
                        w_waddr = f_addr(r_rb);
                        w_wdata = '{epoch: r_epoch, link: f_as_link(r_ra)};
                    end
                    n_state = S_MERGE2;
                end
            end
            S_MERGE2: begin
                w_we = 1'b1;
                if (w_la_fix > w_lb_fix) begin
                    w_waddr = f_addr(r_rb);
                end else begin
                    w_waddr = f_addr(r_ra);
                end
                w_wdata = '{epoch: r_epoch, link: w_sum};
                if (w_total_sum[kuf_pkg::TOTAL_W]) begin
                    n_total = '1;
                end else begin
                    n_total = w_total_sum[kuf_pkg::TOTAL_W-1:0];
                end
                if (r_edges != '1) begin
                    n_edges = r_edges + kuf_pkg::EDGES_W'(1);
                end
                n_taken = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_o_taken    = r_taken;
                    n_o_total    = r_total;
                    n_o_edges    = r_edges;
                    n_o_complete = (r_edges >= r_target);
                    n_o_bad      = r_bad;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_vcount    <= kuf_pkg::VCOUNT_RESET;
            r_epoch     <= '0;
            r_sweep     <= '0;
            r_pend      <= 1'b0;
            r_which     <= 1'b0;
            r_total     <= '0;
            r_edges     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vcount    <= n_vcount;
            r_epoch     <= n_epoch;
            r_sweep     <= n_sweep;
            r_pend      <= n_pend;
            r_which     <= n_which;
            r_total     <= n_total;
            r_edges     <= n_edges;
            r_out_valid <= n_out_valid;
        end
        r_a          <= n_a;
        r_b          <= n_b;
        r_weight     <= n_weight;
        r_bad        <= n_bad;
        r_target     <= n_target;
        r_cur        <= n_cur;
        r_root       <= n_root;
        r_ra         <= n_ra;
        r_rb         <= n_rb;
        r_la         <= n_la;
        r_lb         <= n_lb;
        r_taken      <= n_taken;
        r_o_taken    <= n_o_taken;
        r_o_total    <= n_o_total;
        r_o_edges    <= n_o_edges;
        r_o_complete <= n_o_complete;
        r_o_bad      <= n_o_bad;
    end

    // forest ram: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_forest[w_waddr] <= w_wdata;
        end
        r_rdata <= mem_forest[w_raddr];
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_edge_taken    = r_o_taken;
    assign o_total_weight  = r_o_total;
    assign o_edges_taken   = r_o_edges;
    assign o_tree_complete = r_o_complete;
    assign o_bad_vertex    = r_o_bad;

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("forest written while idle");

    a_merge_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE2) |=> (r_edges == $past(r_edges) + kuf_pkg::EDGES_W'(1)))
        else $error("merge did not count the edge");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && n_out_valid) |-> (r_state == S_DONE))
        else $error("result beat raised outside done");

    a_taken_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE1 && r_ra != r_rb) |-> (!r_bad && r_edges < r_target))
        else $error("merge on bad or complete edge");
`endif

endmodule

`default_nettype wire
